/* rtl/sd_four_line_data_crc_engine_top_assert.svh */
// Assertion macros shared by the CRC engine RTL.
`ifndef SD_FOUR_LINE_DATA_CRC_ENGINE_TOP_ASSERT_SVH
`define SD_FOUR_LINE_DATA_CRC_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SDCRC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdcrc assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SDCRC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdcrc assertion failed");

`endif

/* rtl/sdcrc_pkg.sv */
package sdcrc_pkg;

  // One more than the largest block count the transfer logic supports.
  localparam int unsigned MAX_BLOCKS = 256;
  // Width used to compare the block counter against the capped limit.
  localparam int unsigned LIMIT_W = 17;
  localparam logic [LIMIT_W-1:0] LIMIT_CAP = LIMIT_W'(MAX_BLOCKS - 1);

  localparam int unsigned CRC_W = 64;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned LANE_W = 16;
  localparam int unsigned NUM_LANES = CRC_W / LANE_W;

  // Tap offsets of the packed four-line CRC16 update network.
  localparam int unsigned TAP_A = 5 * 4;
  localparam int unsigned TAP_B = 12 * 4;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_EOB   = 2'd1,
    OP_TOKEN = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_WR_ERR  = 2'd2,
    ST_END     = 2'd3
  } status_t;

  // Card status token codes after dropping the low bit.
  localparam logic [2:0] TOKEN_ACCEPTED = 3'd2;
  localparam logic [2:0] TOKEN_CRC_ERR  = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_TOTAL_BLOCKS = 1'b0;
  localparam logic CFG_SEND_MODE    = 1'b1;

endpackage

/* rtl/sdcrc_if.sv */
// Input item channel.
interface sdcrc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] data_word;
  logic [63:0] received_crc;
  logic [3:0]  status_token;

  modport source (output valid, op, data_word, received_crc, status_token, input ready);
  modport sink (input valid, op, data_word, received_crc, status_token, output ready);
endinterface

// Result item channel.
interface sdcrc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] crc_value;
  logic [1:0]  result_status;
  logic [7:0]  blocks_done;

  modport source (output valid, crc_value, result_status, blocks_done, input ready);
  modport sink (input valid, crc_value, result_status, blocks_done, output ready);
endinterface

/* rtl/sdcrc_update.sv */
// One 32-bit word step of the packed four-line CRC16 network.
module sdcrc_update (
  input  logic [sdcrc_pkg::CRC_W-1:0]  crc,
  input  logic [sdcrc_pkg::WORD_W-1:0] word,
  output logic [sdcrc_pkg::CRC_W-1:0]  crc_next
);

  logic [sdcrc_pkg::WORD_W-1:0] top;
  logic [sdcrc_pkg::WORD_W-1:0] mixed;
  logic [sdcrc_pkg::CRC_W-1:0]  mixed_ext;

  // Fold the upper half of the CRC with the incoming word.
  assign top = sdcrc_pkg::WORD_W'(crc >> sdcrc_pkg::WORD_W);
  assign mixed = top ^ (top >> 16) ^ (word >> 16) ^ word;
  assign mixed_ext = sdcrc_pkg::CRC_W'(mixed);

  // Shift by one word and feed the folded value back at the three taps.
  assign crc_next = (crc << sdcrc_pkg::WORD_W) ^ mixed_ext
                  ^ (mixed_ext << sdcrc_pkg::TAP_A)
                  ^ (mixed_ext << sdcrc_pkg::TAP_B);

endmodule

/* rtl/sdcrc_cmp_lane.sv */
// One 16-bit compare lane: byte-swaps a slice of the running CRC and checks
// it against the matching slice of the CRC read from the card.
module sdcrc_cmp_lane (
  input  logic [sdcrc_pkg::LANE_W-1:0] crc_slice,
  input  logic [sdcrc_pkg::LANE_W-1:0] rx_slice,
  output logic                         match
);

  logic [sdcrc_pkg::LANE_W-1:0] swapped;

  assign swapped = {crc_slice[7:0], crc_slice[15:8]};
  assign match = (swapped == rx_slice);

endmodule

/* rtl/sd_four_line_data_crc_engine_top.sv */
// Four-line SD data CRC engine. Each accepted data word updates a 64-bit
// packed CRC (four interleaved CRC16s, one per data line); an end-of-block
// item returns that CRC and, in receive mode, checks it byte-swapped against
// the card's CRC in four parallel 16-bit compare lanes. In send mode a card
// status token completes each block. A new item is accepted every cycle:
// the CRC network and the lane compare both finish within the accept cycle,
// and one output register holds the result until it is taken, so input
// ready only drops while that register is full and stalled. Once an error
// or the end of the transfer has been reported, items are still accepted
// but dropped until reset. The user must write configuration through
// cfg_we, cfg_index and cfg_data only while idle (the block does not check).
`include "sd_four_line_data_crc_engine_top_assert.svh"

module sd_four_line_data_crc_engine_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  sdcrc_in_if.sink          in_ch,
  sdcrc_out_if.source       out_ch
);

  // Configuration registers.
  logic [7:0] total_blocks;
  logic       send_mode;

  // Block state.
  logic [sdcrc_pkg::CRC_W-1:0] running_crc;
  logic [7:0]                  block_counter;
  logic                        halted;

  logic [sdcrc_pkg::CRC_W-1:0] running_crc_next;
  logic [7:0]                  block_counter_next;
  logic                        halted_next;

  logic                        accept;
  logic                        produce;
  sdcrc_pkg::status_t          status;
  logic [sdcrc_pkg::CRC_W-1:0] crc_out;

  logic [sdcrc_pkg::CRC_W-1:0]     crc_upd;
  logic [sdcrc_pkg::NUM_LANES-1:0] lane_match;
  logic                            crc_match;
  logic [7:0]                      count_inc;
  logic [sdcrc_pkg::LIMIT_W-1:0]   limit;
  logic                            at_limit;
  logic [2:0]                      token_code;
  sdcrc_pkg::op_t                  op;

  // Output register.
  logic                        out_valid;
  logic [sdcrc_pkg::CRC_W-1:0] out_crc;
  sdcrc_pkg::status_t          out_status;
  logic [7:0]                  out_blocks;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;
  assign op = sdcrc_pkg::op_t'(in_ch.op);

  assign out_ch.valid = out_valid;
  assign out_ch.crc_value = out_crc;
  assign out_ch.result_status = out_status;
  assign out_ch.blocks_done = out_blocks;

  // CRC word update network.
  sdcrc_update u_update (
    .crc      (running_crc),
    .word     (in_ch.data_word),
    .crc_next (crc_upd)
  );

  // Compare lanes: lane k checks bytes 2k and 2k+1 of the swapped CRC.
  for (genvar k = 0; k < sdcrc_pkg::NUM_LANES; k++) begin : g_lane
    sdcrc_cmp_lane u_lane (
      .crc_slice (running_crc[sdcrc_pkg::LANE_W*(sdcrc_pkg::NUM_LANES-1-k) +:
                              sdcrc_pkg::LANE_W]),
      .rx_slice  (in_ch.received_crc[sdcrc_pkg::LANE_W*k +: sdcrc_pkg::LANE_W]),
      .match     (lane_match[k])
    );
  end

  // Merge the lane results.
  assign crc_match = &lane_match;

  // Block limit, capped at the largest supported count.
  assign count_inc = block_counter + 8'd1;
  assign limit = (sdcrc_pkg::LIMIT_W'(total_blocks) < sdcrc_pkg::LIMIT_CAP) ?
                 sdcrc_pkg::LIMIT_W'(total_blocks) : sdcrc_pkg::LIMIT_CAP;
  assign at_limit = (sdcrc_pkg::LIMIT_W'(count_inc) >= limit);
  assign token_code = in_ch.status_token[3:1];

  // Item decode and next state.
  always_comb begin
    produce = 1'b0;
    status = sdcrc_pkg::ST_OK;
    crc_out = '0;
    running_crc_next = running_crc;
    block_counter_next = block_counter;
    halted_next = halted;
    if (!halted) begin
      unique case (op)
        sdcrc_pkg::OP_DATA: begin
          running_crc_next = crc_upd;
        end
        sdcrc_pkg::OP_EOB: begin
          produce = 1'b1;
          crc_out = running_crc;
          running_crc_next = '0;
          if (!send_mode) begin
            if (!crc_match) begin
              status = sdcrc_pkg::ST_CRC_ERR;
              halted_next = 1'b1;
            end else begin
              block_counter_next = count_inc;
              if (at_limit) begin
                status = sdcrc_pkg::ST_END;
                halted_next = 1'b1;
              end
            end
          end
        end
        sdcrc_pkg::OP_TOKEN: begin
          if (send_mode) begin
            produce = 1'b1;
            priority if (token_code == sdcrc_pkg::TOKEN_CRC_ERR) begin
              status = sdcrc_pkg::ST_CRC_ERR;
              halted_next = 1'b1;
            end else if (token_code != sdcrc_pkg::TOKEN_ACCEPTED) begin
              status = sdcrc_pkg::ST_WR_ERR;
              halted_next = 1'b1;
            end else begin
              block_counter_next = count_inc;
              if (at_limit) begin
                status = sdcrc_pkg::ST_END;
                halted_next = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks <= 8'd1;
      send_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdcrc_pkg::CFG_TOTAL_BLOCKS: total_blocks <= cfg_data;
        sdcrc_pkg::CFG_SEND_MODE:    send_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Block state advances on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
      block_counter <= '0;
      halted <= 1'b0;
    end else if (accept) begin
      running_crc <= running_crc_next;
      block_counter <= block_counter_next;
      halted <= halted_next;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= accept && produce;
    end
  end

  // Output payload loads with each new result.
  always_ff @(posedge clk) begin
    if (accept && produce) begin
      out_crc <= crc_out;
      out_status <= status;
      out_blocks <= block_counter_next;
    end
  end

  `SDCRC_ASSERT_NEXT(a_halted_sticks, clk, rst, halted, halted)
  `SDCRC_ASSERT_NEXT(a_halted_drops, clk, rst, accept && halted, !out_ch.valid)
  `SDCRC_ASSERT_NEXT(a_error_halts, clk, rst,
                     accept && produce && (status != sdcrc_pkg::ST_OK), halted)
  `SDCRC_ASSERT_NEXT(a_counter_idle, clk, rst, !accept, $stable(block_counter))
  `SDCRC_ASSERT_NEXT(a_eob_clears, clk, rst,
                     accept && !halted && (op == sdcrc_pkg::OP_EOB), running_crc == '0)

endmodule
